>>> hdl/bsu_pkg.sv
package bsu_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int STR_W     = 17;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 31;
  localparam int CFG_W     = 3;
  localparam int EXP_FRAC  = 28;
  localparam int DVD_W     = 33;
  localparam int DSR_W     = 47;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STR_W-1:0]          ONE      = STR_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0]  ONE_S    = DATA_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0]          ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [EXP_FRAC:0]         ONE_I    = (EXP_FRAC+1)'(1) << EXP_FRAC;
  localparam logic [DATA_W-1:0]         LOG2E_Q30 = 32'd1549082005;
  localparam logic [DATA_W-1:0]         LN2_Q28   = 32'd186065280;
  localparam logic [DVD_W-1:0]          ONE_SQ   = DVD_W'(1) << (2 * FRAC_BITS);
  localparam logic [3:0]                TAYLOR_TERMS = 4'd10;

  // Register indexes
  localparam logic REG_AGG_MODE  = 1'b0;
  localparam logic REG_INFL_MODE = 1'b1;

  typedef enum logic [1:0] {
    AGG_SUM  = 2'd0,
    AGG_PROD = 2'd1,
    AGG_TOP  = 2'd2
  } agg_mode_t;

  typedef enum logic [2:0] {
    INF_SIMPLE = 3'd0,
    INF_LINEAR = 3'd1,
    INF_EULER  = 3'd2,
    INF_MAX1   = 3'd3,
    INF_MAX2   = 3'd4
  } infl_mode_t;

  typedef enum logic [4:0] {
    B_IDLE, B_DISP, B_HSTART, B_HWAIT, B_SQ, B_SQ2, B_HMUL, B_FIN,
    B_E1, B_E2, B_E3, B_EU, B_E4, B_E5, B_E6, B_E7, B_E8, B_E9, B_E10,
    B_OUT
  } back_state_t;

  // One finished argument handed from front to back
  typedef struct packed {
    logic [STR_W-1:0]         weight;
    logic signed [DATA_W-1:0] agg;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> hdl/bsu_div.sv
module bsu_div (
  input  logic                     clk,
  input  logic                     rst,
  input  bsu_pkg::div_req_t        req,
  output logic                     done,
  output logic [bsu_pkg::DVD_W-1:0] quotient
);
  import bsu_pkg::*;

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DVD_W-1:0] quo;
  logic [5:0]       cnt;
  logic             busy;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;
  logic             ge;

  // One restoring step per cycle
  always_comb begin
    rem_sh = {rem, quo[DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> hdl/bsu_queue.sv
module bsu_queue #(
  parameter int DEPTH = bsu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bsu_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output bsu_pkg::entry_t pop_data,
  output logic            not_empty
);
  import bsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/bsu_front.sv
module bsu_front (
  input  logic                       clk,
  input  logic                       rst,
  input  bsu_pkg::agg_mode_t         agg_mode,
  input  logic                       acc_clear,
  input  bsu_pkg::agg_mode_t         clear_mode,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bsu_pkg::STR_W-1:0]  strength,
  input  logic                       is_supporter,
  input  logic                       carries_strength,
  input  logic                       last_of_argument,
  input  logic [bsu_pkg::STR_W-1:0]  initial_strength,
  output logic                       q_push,
  output bsu_pkg::entry_t            q_data,
  input  logic                       q_full
);
  import bsu_pkg::*;

  logic [ACC_W-1:0]   att_acc;
  logic [ACC_W-1:0]   sup_acc;
  logic [ACC_W-1:0]   att_next;
  logic [ACC_W-1:0]   sup_next;
  logic [ACC_W-1:0]   acc_sel;
  logic [ACC_W-1:0]   upd;
  logic [STR_W-1:0]   st_c;
  logic [STR_W-1:0]   w_c;
  logic [ACC_W+STR_W-1:0] prod;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   ident;
  logic [ACC_W-1:0]   clear_ident;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Clamp inputs to one, then fold the strength into its side
  always_comb begin
    st_c    = (strength > ONE) ? ONE : strength;
    w_c     = (initial_strength > ONE) ? ONE : initial_strength;
    acc_sel = is_supporter ? sup_acc : att_acc;
    prod    = acc_sel * (ONE - st_c);
    sum     = {1'b0, acc_sel} + (ACC_W+1)'(st_c);
    case (agg_mode)
      AGG_PROD: upd = prod[ACC_W+FRAC_BITS-1:FRAC_BITS];
      AGG_TOP:  upd = (ACC_W'(st_c) > acc_sel) ? ACC_W'(st_c) : acc_sel;
      default:  upd = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endcase
    att_next = (carries_strength && !is_supporter) ? upd : att_acc;
    sup_next = (carries_strength && is_supporter) ? upd : sup_acc;
    ident       = (agg_mode == AGG_PROD) ? ACC_W'(ONE) : '0;
    clear_ident = (clear_mode == AGG_PROD) ? ACC_W'(ONE) : '0;
  end

  // Aggregate sign depends on mode
  always_comb begin
    q_push        = accept && last_of_argument;
    q_data.weight = w_c;
    if (agg_mode == AGG_PROD) begin
      q_data.agg = $signed({1'b0, att_next}) - $signed({1'b0, sup_next});
    end else begin
      q_data.agg = $signed({1'b0, sup_next}) - $signed({1'b0, att_next});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      att_acc <= '0;
      sup_acc <= '0;
    end else if (acc_clear) begin
      att_acc <= clear_ident;
      sup_acc <= clear_ident;
    end else if (accept) begin
      if (last_of_argument) begin
        att_acc <= ident;
        sup_acc <= ident;
      end else begin
        att_acc <= att_next;
        sup_acc <= sup_next;
      end
    end
  end

endmodule

>>> hdl/bsu_back.sv
module bsu_back (
  input  logic                              clk,
  input  logic                              rst,
  input  bsu_pkg::infl_mode_t               infl_mode,
  input  logic                              q_valid,
  input  bsu_pkg::entry_t                   q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bsu_pkg::DATA_W-1:0] new_strength,
  output logic signed [bsu_pkg::DATA_W-1:0] aggregate_value
);
  import bsu_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [STR_W-1:0]         w;
  logic signed [DATA_W-1:0] s;
  logic [DATA_W-1:0]        mag;
  logic                     pos;
  logic                     neg;
  logic [DATA_W-1:0]        xop;
  logic [DSR_W-1:0]         den;
  logic signed [4:0]        n;
  logic [EXP_FRAC-1:0]      f;
  logic [EXP_FRAC-1:0]      u;
  logic [EXP_FRAC:0]        term;
  logic [EXP_FRAC+1:0]      eacc;
  logic [3:0]               k;
  logic [EXP_FRAC:0]        e;
  logic [STR_W-1:0]         num;
  logic signed [DATA_W-1:0] res;
  logic [2*DATA_W-1:0]      prod;

  logic [DATA_W-1:0]        mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic [STR_W-1:0]         m;
  logic [DATA_W-1:0]        clamp_mag;
  logic [32:0]              t_floor;
  logic [32:0]              t_ceil;
  logic signed [33:0]       t;
  logic signed [5:0]        sh_s;
  logic [32:0]              infl_term;
  logic                     load_out;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DVD_W-1:0]         div_q;

  // ceil(2^31 / k); x * recip >> 31 is exact floor(x / k) for 28-bit x, k in 1..10
  function automatic logic [DATA_W-1:0] taylor_recip(input logic [3:0] kk);
    case (kk)
      4'd2:    return 32'd1073741824;
      4'd3:    return 32'd715827883;
      4'd4:    return 32'd536870912;
      4'd5:    return 32'd429496730;
      4'd6:    return 32'd357913942;
      4'd7:    return 32'd306783379;
      4'd8:    return 32'd268435456;
      4'd9:    return 32'd238609295;
      4'd10:   return 32'd214748365;
      default: return 32'd2147483648;
    endcase
  endfunction

  bsu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Datapath helpers
  always_comb begin
    m         = pos ? (ONE - w) : w;
    clamp_mag = (mag > (DATA_W'(ONE) << 3)) ? (DATA_W'(ONE) << 3) : mag;
    t_floor   = prod[62:30];
    t_ceil    = 33'((prod[62:0] + 63'h3fffffff) >> 30);
    t         = neg ? -$signed({1'b0, t_ceil}) : $signed({1'b0, t_floor});
    sh_s      = 6'sd12 - $signed({n[4], n});
    infl_term = prod[48:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, multiplier operands, divider requests
  always_comb begin
    state_next       = state;
    q_pop            = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    load_out         = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_DISP;
        end
      end
      B_DISP: begin
        case (infl_mode)
          INF_LINEAR: state_next = B_HMUL;
          INF_EULER:  state_next = B_E1;
          INF_MAX1:   state_next = (mag == '0) ? B_HMUL : B_HSTART;
          INF_MAX2:   state_next = (mag == '0) ? B_HMUL : B_SQ;
          default:    state_next = B_OUT;
        endcase
      end
      B_SQ: begin
        mul_a      = mag;
        mul_b      = mag;
        state_next = B_SQ2;
      end
      B_SQ2: state_next = B_HSTART;
      B_HSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = ONE_SQ;
        div_req.divisor  = den;
        state_next       = B_HWAIT;
      end
      B_HWAIT: if (div_done) state_next = B_HMUL;
      B_HMUL: begin
        mul_a      = DATA_W'(m);
        mul_b      = xop;
        state_next = B_FIN;
      end
      B_FIN: state_next = B_OUT;
      B_E1: begin
        mul_a      = xop;
        mul_b      = LOG2E_Q30;
        state_next = B_E2;
      end
      B_E2: state_next = B_E3;
      B_E3: begin
        mul_a      = DATA_W'(f);
        mul_b      = LN2_Q28;
        state_next = B_EU;
      end
      B_EU: state_next = B_E4;
      B_E4: begin
        mul_a      = DATA_W'(term);
        mul_b      = DATA_W'(u);
        state_next = B_E5;
      end
      // Divide the new term by k through its reciprocal
      B_E5: begin
        mul_a      = DATA_W'(prod[55:28]);
        mul_b      = taylor_recip(k);
        state_next = B_E6;
      end
      B_E6: state_next = (k == TAYLOR_TERMS) ? B_E7 : B_E4;
      B_E7: begin
        mul_a      = DATA_W'(w);
        mul_b      = DATA_W'(w);
        state_next = B_E8;
      end
      B_E8: begin
        mul_a      = DATA_W'(w);
        mul_b      = DATA_W'(e);
        state_next = B_E9;
      end
      B_E9: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(num) << FRAC_BITS;
        div_req.divisor  = DSR_W'(ONE) + DSR_W'(prod[46:16]);
        state_next       = B_E10;
      end
      B_E10: if (div_done) state_next = B_OUT;
      B_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      B_IDLE: begin
        w   <= q_data.weight;
        s   <= q_data.agg;
        mag <= q_data.agg[DATA_W-1] ? DATA_W'(-q_data.agg) : DATA_W'(q_data.agg);
        pos <= !q_data.agg[DATA_W-1] && (q_data.agg != '0);
        neg <= q_data.agg[DATA_W-1];
      end
      B_DISP: begin
        res <= sat32(36'(s) + $signed({19'd0, w}));
        den <= DSR_W'(ONE) + DSR_W'(mag);
        if (infl_mode == INF_EULER) begin
          xop <= clamp_mag << (EXP_FRAC - FRAC_BITS);
        end else if (infl_mode == INF_LINEAR) begin
          xop <= mag;
        end else begin
          xop <= '0;
        end
      end
      B_SQ2: den <= DSR_W'(ONE) + DSR_W'(prod[61:16]);
      B_HWAIT: if (div_done) xop <= DATA_W'(ONE) - DATA_W'(div_q);
      B_FIN: begin
        if (pos) begin
          res <= sat32($signed({19'd0, w}) + $signed({3'd0, infl_term}));
        end else begin
          res <= sat32($signed({19'd0, w}) - $signed({3'd0, infl_term}));
        end
      end
      B_E2: begin
        n <= t[32:28];
        f <= t[27:0];
      end
      B_EU: begin
        u    <= prod[55:28];
        term <= ONE_I;
        eacc <= (EXP_FRAC+2)'(ONE_I);
        k    <= 4'd1;
      end
      // Quotient sits above bit 31 of the reciprocal product
      B_E6: begin
        term <= (EXP_FRAC+1)'(prod[58:31]);
        eacc <= eacc + (EXP_FRAC+2)'(prod[58:31]);
        k    <= k + 4'd1;
      end
      B_E7: e <= (EXP_FRAC+1)'(eacc >> sh_s[4:0]);
      B_E8: num <= ONE - prod[32:16];
      B_E10: if (div_done) res <= ONE_S - $signed({1'b0, div_q[DATA_W-2:0]});
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_strength    <= res;
      aggregate_value <= s;
    end
  end

endmodule

>>> hdl/bipolar_strength_update_top.sv
// Channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------------
// in        | in_valid / in_stall        | strength, is_supporter, carries_strength,
//           |                            | last_of_argument, initial_strength
// out       | out_valid / out_stall      | new_strength, aggregate_value
// cfg       | cfg_write_en               | cfg_index, cfg_data
//
// The front folds one beat per cycle into the side accumulators while the queue is
// not full; a last beat pushes the aggregate into a two-entry queue and the front
// moves on at once. The back sequencer runs a 33-step divide for 1-Max and 2-Max
// when the aggregate is nonzero, and for Euler after ten Taylor steps.
// in_stall rises only while the queue is full. Synchronous reset, no clearing pass.
module bipolar_strength_update_top #(
  parameter int QUEUE_DEPTH = bsu_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic                              cfg_index,
  input  logic [bsu_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bsu_pkg::STR_W-1:0]         strength,
  input  logic                              is_supporter,
  input  logic                              carries_strength,
  input  logic                              last_of_argument,
  input  logic [bsu_pkg::STR_W-1:0]         initial_strength,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bsu_pkg::DATA_W-1:0] new_strength,
  output logic signed [bsu_pkg::DATA_W-1:0] aggregate_value
);
  import bsu_pkg::*;

  agg_mode_t  agg_mode;
  infl_mode_t infl_mode;
  logic       acc_clear;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  entry_t     q_in;
  entry_t     q_out;

  // Configuration registers
  assign acc_clear = cfg_write_en && (cfg_index == REG_AGG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode  <= AGG_SUM;
      infl_mode <= INF_SIMPLE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_AGG_MODE:  agg_mode  <= agg_mode_t'(cfg_data[1:0]);
        REG_INFL_MODE: infl_mode <= infl_mode_t'(cfg_data);
        default: ;
      endcase
    end
  end

  bsu_front u_front (
    .clk              (clk),
    .rst              (rst),
    .agg_mode         (agg_mode),
    .acc_clear        (acc_clear),
    .clear_mode       (agg_mode_t'(cfg_data[1:0])),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .strength         (strength),
    .is_supporter     (is_supporter),
    .carries_strength (carries_strength),
    .last_of_argument (last_of_argument),
    .initial_strength (initial_strength),
    .q_push           (q_push),
    .q_data           (q_in),
    .q_full           (q_full)
  );

  bsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  bsu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .infl_mode       (infl_mode),
    .q_valid         (q_valid),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_strength    (new_strength),
    .aggregate_value (aggregate_value)
  );

`ifndef NO_ASSERTIONS
  // Product and top aggregates never leave [-1, 1]
  a_agg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (agg_mode == AGG_PROD || agg_mode == AGG_TOP) |->
      aggregate_value <= ONE_S && aggregate_value >= -ONE_S)
    else $error("aggregate out of range");

  // Euler and max influences stay in [0, 1]
  a_infl_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (infl_mode == INF_EULER || infl_mode == INF_MAX1 ||
                  infl_mode == INF_MAX2) |->
      new_strength >= 0 && new_strength <= ONE_S)
    else $error("influence out of range");
`endif

endmodule

>>> tb/tb.sv
module tb;
  import bsu_pkg::*;

  localparam longint Q1 = 64'sd1 << 16;
  localparam longint LOG2E = 64'sd1549082005;
  localparam longint LN2 = 64'sd186065280;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [STR_W-1:0] st;
    bit               sup;
    bit               car;
    bit               last;
    logic [STR_W-1:0] w;
  } beat_t;

  typedef struct {
    logic signed [31:0] ns;
    logic signed [31:0] agg;
  } update_t;

  logic clk, rst;
  logic cfg_write_en, cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [STR_W-1:0] strength, initial_strength;
  logic is_supporter, carries_strength, last_of_argument;
  logic out_valid, out_stall;
  logic signed [DATA_W-1:0] new_strength, aggregate_value;

  bipolar_strength_update_top u_top (.*);

  // model state
  logic [1:0] agg_mode_q;
  logic [2:0] infl_mode_q;
  longint att_acc, sup_acc;

  beat_t   pending_beats[$];
  update_t expected_updates[$];
  bit in_taken;
  bit idle_on;
  int hold_reqs, hold_seen, hold_left;
  int mismatches, results_seen, watchdog;
  int euler_seen, sat_seen;
  int n_beats;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_accs();
    att_acc = (agg_mode_q == AGG_PROD) ? Q1 : 0;
    sup_acc = att_acc;
  endfunction

  // exp via 2^(s*log2 e), 28-bit fraction internally
  function automatic longint exp_q16(longint s);
    longint t, n, f, u, term, acc, sh;
    t = ((s <<< 12) * LOG2E) >>> 30;
    n = t >>> 28;
    f = t - (n <<< 28);
    u = (f * LN2) >>> 28;
    term = 64'sd1 << 28;
    acc = term;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * u) >>> 28) / k;
      acc += term;
    end
    sh = n + 16 - 28;
    if (sh >= 0) return acc <<< sh;
    return acc >>> (-sh);
  endfunction

  function automatic longint max_curve(longint x, bit sq);
    longint xp;
    if (x <= 0) return 0;
    xp = sq ? ((x * x) >>> 16) : x;
    return Q1 - (Q1 * Q1) / (Q1 + xp);
  endfunction

  function automatic longint influence_of(longint w, longint s);
    longint pos, neg, sc, e, num, den;
    pos = (s > 0) ? s : 0;
    neg = (s < 0) ? -s : 0;
    case (infl_mode_q)
      INF_LINEAR: return w - ((w * neg) >>> 16) + (((Q1 - w) * pos) >>> 16);
      INF_EULER: begin
        sc = (s > 8 * Q1) ? 8 * Q1 : ((s < -8 * Q1) ? -8 * Q1 : s);
        e = exp_q16(sc);
        num = Q1 - ((w * w) >>> 16);
        den = Q1 + ((w * e) >>> 16);
        return Q1 - (num * Q1) / den;
      end
      INF_MAX1, INF_MAX2: begin
        return w - ((w * max_curve(neg, infl_mode_q == INF_MAX2)) >>> 16)
                 + (((Q1 - w) * max_curve(pos, infl_mode_q == INF_MAX2)) >>> 16);
      end
      default: return w + s;
    endcase
  endfunction

  // fold one beat into the side accumulators; returns 1 when it closes an argument
  function automatic bit predict_update(beat_t b, output update_t r);
    longint st, w, agg;
    st = (b.st > Q1) ? Q1 : b.st;
    w = (b.w > Q1) ? Q1 : b.w;
    if (b.car) begin
      if (agg_mode_q == AGG_PROD) begin
        if (b.sup) sup_acc = (sup_acc * (Q1 - st)) >>> 16;
        else att_acc = (att_acc * (Q1 - st)) >>> 16;
      end else if (agg_mode_q == AGG_TOP) begin
        if (b.sup) begin
          if (st > sup_acc) sup_acc = st;
        end else if (st > att_acc) att_acc = st;
      end else begin
        if (b.sup) sup_acc = (sup_acc + st > 64'sd2147483647) ? 64'sd2147483647 : sup_acc + st;
        else att_acc = (att_acc + st > 64'sd2147483647) ? 64'sd2147483647 : att_acc + st;
      end
    end
    if (!b.last) return 0;
    agg = (agg_mode_q == AGG_PROD) ? att_acc - sup_acc : sup_acc - att_acc;
    agg = sat_32(agg);
    r.agg = agg;
    r.ns = sat_32(influence_of(w, agg));
    clear_accs();
    return 1;
  endfunction

  // monitor: config, accepted input beats, accepted results, watchdog
  always @(posedge clk) begin
    update_t r, exp_r;
    bit any;
    if (rst) begin
      agg_mode_q = 2'd0;
      infl_mode_q = 3'd0;
      clear_accs();
      in_taken = 0;
      watchdog = 0;
    end else begin
      any = 0;
      in_taken = in_valid && !in_stall;
      if (cfg_write_en) begin
        any = 1;
        if (cfg_index == REG_AGG_MODE) begin
          agg_mode_q = cfg_data[1:0];
          clear_accs();
        end else infl_mode_q = cfg_data;
      end
      if (in_taken) begin
        any = 1;
        if (predict_update('{strength, is_supporter, carries_strength,
                             last_of_argument, initial_strength}, r)) begin
          expected_updates.push_back(r);
          if (infl_mode_q == INF_EULER) euler_seen++;
        end
      end
      if (out_valid && !out_stall) begin
        any = 1;
        results_seen++;
        if (expected_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ns=%0d agg=%0d", new_strength, aggregate_value);
        end else begin
          exp_r = expected_updates.pop_front();
          if (exp_r.ns == 32'sh7fffffff || exp_r.ns == 32'sh80000000) sat_seen++;
          if (new_strength !== exp_r.ns || aggregate_value !== exp_r.agg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: ns exp %0d got %0d, agg exp %0d got %0d",
                       exp_r.ns, new_strength, exp_r.agg, aggregate_value);
          end
        end
      end
      watchdog = any ? 0 : watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", expected_updates.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() > 0 && !(idle_on && $urandom_range(99) < 12)) begin
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        strength <= b.st;
        is_supporter <= b.sup;
        carries_strength <= b.car;
        last_of_argument <= b.last;
        initial_strength <= b.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 12);
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [STR_W-1:0] rand_strength();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE;
      2: return STR_W'($urandom_range(65537, 131071));
      default: return STR_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic void add_beat(logic [STR_W-1:0] st, bit sup, bit car, bit last,
                                   logic [STR_W-1:0] w);
    beat_t b;
    b.st = st; b.sup = sup; b.car = car; b.last = last; b.w = w;
    pending_beats.push_back(b);
    n_beats++;
  endfunction

  // one argument: some strength beats, then a closing beat
  function automatic int add_argument();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++)
      add_beat(rand_strength(), $urandom_range(1), $urandom_range(19) != 0, 0,
               STR_W'($urandom));
    add_beat(rand_strength(), $urandom_range(1), $urandom_range(1), 1, rand_strength());
    return n + 1;
  endfunction

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid && expected_updates.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    strength = '0; is_supporter = 0; carries_strength = 0;
    last_of_argument = 0; initial_strength = '0;
    idle_on = 1; hold_reqs = 0;
    mismatches = 0; results_seen = 0; euler_seen = 0; sat_seen = 0;
    n_beats = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, clamping, close-only beats, empty argument
    add_beat('0, 0, 0, 1, '0);
    add_beat(ONE, 1, 1, 1, ONE);
    add_beat(17'h1ffff, 0, 1, 1, 17'h1ffff);
    add_beat(ONE, 1, 1, 0, '0);
    add_beat(ONE, 1, 1, 0, '0);
    add_beat(17'h1ffff, 0, 1, 0, '0);
    add_beat(17'h0aaaa, 1, 0, 1, 17'h15555);
    add_beat(ONE, 0, 1, 0, '0);
    add_beat(17'h08000, 1, 1, 1, 17'h08000);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_AGG_MODE, CFG_W'(m));
      for (int f = 0; f < 8; f += 1 + (m % 2)) begin
        write_reg(REG_INFL_MODE, CFG_W'(f));
        add_beat(ONE, 1, 1, 0, '0);
        add_beat(17'h04000, 0, 1, 1, 17'h0c000);
        drain();
      end
    end

    // random phases over register settings
    for (int p = 0; n_beats < 750; p++) begin
      write_reg(REG_AGG_MODE, (p % 5 == 4) ? CFG_W'(7) : CFG_W'(p % 4));
      write_reg(REG_INFL_MODE, CFG_W'((p * 3) % 8));
      idle_on = (p != 5);
      if (p == 2) hold_reqs++;
      for (int k = 0; k < 45; k += 0) begin
        k += add_argument();
        if ($urandom_range(9) == 0) add_beat(rand_strength(), $urandom_range(1), 0, 0, '0);
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("%0d beats sent, %0d results checked (%0d Euler, %0d saturated)",
             n_beats, results_seen, euler_seen, sat_seen);
    $display("all aggregation and influence modes exercised, with stalls and a long hold-off");
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
